>>> hdl/svdl_pkg.sv
package svdl_pkg;

  typedef struct packed {
    logic signed [15:0] sample_i;
    logic signed [15:0] sample_q;
    logic               block_start;
    logic [47:0]        block_time;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_i;
    logic signed [15:0] out_q;
  } out_item_t;

  typedef struct packed {
    logic [12:0] delay_min_samples;
    logic [12:0] delay_max_samples;
    logic [39:0] period_samples;
    logic [39:0] start_offset_samples;
  } cfg_t;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MAX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 2'd3;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] Q30_ONE    = 64'd1 << 30;

  // quarter-wave sine in q15, taylor series to degree 13 in q30 horner form
  function automatic logic [15:0] quarter_sine(int unsigned r, int unsigned tb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] dec;
    logic [63:0] s;
    x   = ((64'(r) * TWO_PI_Q30) + (64'd1 << (tb - 1))) >> tb;
    x2  = (x * x) >> 30;
    t   = Q30_ONE;
    dec = ((x2 * t) >> 30) / 64'd156;
    t   = (dec >= Q30_ONE) ? 64'd0 : Q30_ONE - dec;
    dec = ((x2 * t) >> 30) / 64'd110;
    t   = (dec >= Q30_ONE) ? 64'd0 : Q30_ONE - dec;
    dec = ((x2 * t) >> 30) / 64'd72;
    t   = (dec >= Q30_ONE) ? 64'd0 : Q30_ONE - dec;
    dec = ((x2 * t) >> 30) / 64'd42;
    t   = (dec >= Q30_ONE) ? 64'd0 : Q30_ONE - dec;
    dec = ((x2 * t) >> 30) / 64'd20;
    t   = (dec >= Q30_ONE) ? 64'd0 : Q30_ONE - dec;
    dec = ((x2 * t) >> 30) / 64'd6;
    t   = (dec >= Q30_ONE) ? 64'd0 : Q30_ONE - dec;
    s   = (x * t) >> 30;
    s   = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return s[15:0];
  endfunction

  function automatic logic signed [15:0] sine_entry(int unsigned k, int unsigned tb);
    int unsigned quarter;
    int unsigned q;
    int unsigned r;
    logic [15:0] v;
    quarter = 1 << (tb - 2);
    q = k >> (tb - 2);
    r = k & (quarter - 1);
    v = q[0] ? quarter_sine(quarter - r, tb) : quarter_sine(r, tb);
    return q[1] ? -$signed(v) : $signed(v);
  endfunction

endpackage

>>> hdl/sinusoidal_variable_delay_line.sv
// path: a pushed sample passes the input queue, the issue registers and the output queue
// throughput: one sample per cycle between block starts while the output queue has room
// block start with a nonzero period: the delay divider takes the phase modulo the period, then
//   divides it into a table index, looks it up, multiplies and rounds; zeros are appended when the delay grows
// reset clears config, pointers, fill count and delay; the sample store is not cleared
module sinusoidal_variable_delay_line #(
  parameter int MAX_DELAY       = 4096,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  svdl_pkg::in_item_t                   in_data_i,
  output logic                                 empty,
  input  logic                                 pop,
  output svdl_pkg::out_item_t                  out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [svdl_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [39:0]                          cfg_data_i
);
  import svdl_pkg::*;

  localparam int DW = $clog2(MAX_DELAY + 1);

  cfg_t          cfg_q;
  logic          f_valid;
  in_item_t      f_item;
  logic          f_pop;
  logic          calc_start;
  logic          calc_done;
  logic [DW-1:0] calc_delay;
  logic          out_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DELAY_MIN:    cfg_q.delay_min_samples    <= cfg_data_i[12:0];
        CFG_DELAY_MAX:    cfg_q.delay_max_samples    <= cfg_data_i[12:0];
        CFG_PERIOD:       cfg_q.period_samples       <= cfg_data_i;
        CFG_START_OFFSET: cfg_q.start_offset_samples <= cfg_data_i;
        default: ;
      endcase
    end
  end

  svdl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_data_i),
    .full_o  (full),
    .valid_o (f_valid),
    .item_o  (f_item),
    .pop_i   (f_pop)
  );

  svdl_delay_calc #(
    .MAX_DELAY       (MAX_DELAY),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .DW              (DW)
  ) u_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .start_i (calc_start),
    .time_i  (f_item.block_time),
    .done_o  (calc_done),
    .delay_o (calc_delay)
  );

  svdl_back #(
    .MAX_DELAY   (MAX_DELAY),
    .SAMPLE_BITS (SAMPLE_BITS),
    .DW          (DW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (f_valid),
    .item_i       (f_item),
    .item_pop_o   (f_pop),
    .calc_start_o (calc_start),
    .calc_done_i  (calc_done),
    .calc_delay_i (calc_delay),
    .out_valid_o  (out_valid),
    .out_data_o   (out_data_o),
    .out_pop_i    (pop)
  );

  assign empty = !out_valid;

endmodule

>>> hdl/svdl_front.sv
module svdl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  svdl_pkg::in_item_t item_i,
  output logic               full_o,
  output logic               valid_o,
  output svdl_pkg::in_item_t item_o,
  input  logic               pop_i
);
  import svdl_pkg::*;

  in_item_t    slot_q [4];
  logic [1:0]  wr_ptr_q;
  logic [1:0]  rd_ptr_q;
  logic [2:0]  count_q;
  logic        do_push;
  logic        do_pop;

  assign full_o  = (count_q == 3'd4);
  assign valid_o = (count_q != 3'd0);
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 2'd1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 2'd1;
      count_q <= count_q + {2'b0, do_push} - {2'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= item_i;
  end

endmodule

>>> hdl/svdl_delay_calc.sv
module svdl_delay_calc #(
  parameter int MAX_DELAY       = 4096,
  parameter int SINE_TABLE_BITS = 10,
  parameter int DW              = 13
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  svdl_pkg::cfg_t cfg_i,
  input  logic           start_i,
  input  logic [47:0]    time_i,
  output logic           done_o,
  output logic [DW-1:0]  delay_o
);
  import svdl_pkg::*;

  localparam int TB  = SINE_TABLE_BITS;
  localparam int N   = 1 << TB;
  localparam int DVW = (42 + TB > 49) ? 42 + TB : 49;
  localparam int CW  = $clog2(DVW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_IDX  = 3'd2;
  localparam logic [2:0] S_LUT  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_RND  = 3'd5;

  logic signed [15:0] sine_rom [N];

  for (genvar k = 0; k < N; k++) begin : g_rom
    localparam logic signed [15:0] SINE_VAL = sine_entry(k, TB);
    assign sine_rom[k] = SINE_VAL;
  end

  logic [2:0]         state_q;
  logic [DVW-1:0]     dvd_q;
  logic [40:0]        rem_q;
  logic [40:0]        dvs_q;
  logic [CW-1:0]      cnt_q;
  logic [TB-1:0]      idx_q;
  logic signed [15:0] sine_q;
  logic signed [30:0] prod_q;
  logic [DW-1:0]      delay_q;
  logic               done_q;

  logic [41:0]        cand;
  logic               ge;
  logic [40:0]        rem_n;
  logic [DVW-1:0]     dvd_n;
  logic               last_step;
  logic signed [13:0] diff;
  logic signed [16:0] wgt;
  logic signed [30:0] prod_d;
  logic signed [30:0] absn;
  logic [14:0]        rmag;
  logic signed [31:0] dsum;
  logic [DW-1:0]      delay_rnd;
  logic [DW-1:0]      delay_fix;

  // one restoring division step per cycle, quotient shifts into the dividend
  always_comb begin
    cand      = {rem_q, dvd_q[DVW-1]};
    ge        = (cand >= {1'b0, dvs_q});
    rem_n     = ge ? 41'(cand - {1'b0, dvs_q}) : cand[40:0];
    dvd_n     = {dvd_q[DVW-2:0], ge};
    last_step = (cnt_q == CW'(DVW - 1));
  end

  always_comb begin
    diff   = $signed({1'b0, cfg_i.delay_max_samples}) - $signed({1'b0, cfg_i.delay_min_samples});
    wgt    = 17'sd32768 + {sine_q[15], sine_q};
    prod_d = diff * wgt;
    absn   = prod_q[30] ? -prod_q : prod_q;
    rmag   = 15'((absn + 31'sd32768) >>> 16);
    dsum   = $signed({19'b0, cfg_i.delay_min_samples})
             + (prod_q[30] ? -$signed({17'b0, rmag}) : $signed({17'b0, rmag}));
    if (dsum < 32'sd0) delay_rnd = '0;
    else if (dsum > 32'sd0 + MAX_DELAY) delay_rnd = DW'(MAX_DELAY);
    else delay_rnd = DW'(dsum);
    if (32'(cfg_i.delay_max_samples) > 32'(MAX_DELAY)) delay_fix = DW'(MAX_DELAY);
    else delay_fix = DW'(cfg_i.delay_max_samples);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            if (cfg_i.period_samples == '0) begin
              done_q <= 1'b1;
            end else begin
              state_q <= S_MOD;
              cnt_q   <= '0;
            end
          end
        end
        S_MOD: begin
          cnt_q <= cnt_q + CW'(1);
          if (last_step) begin
            state_q <= S_IDX;
            cnt_q   <= '0;
          end
        end
        S_IDX: begin
          cnt_q <= cnt_q + CW'(1);
          if (last_step) state_q <= S_LUT;
        end
        S_LUT: state_q <= S_MUL;
        S_MUL: state_q <= S_RND;
        S_RND: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        dvd_q   <= DVW'(49'(time_i) + 49'(cfg_i.start_offset_samples));
        rem_q   <= '0;
        dvs_q   <= {1'b0, cfg_i.period_samples};
        delay_q <= delay_fix;
      end
      S_MOD: begin
        dvd_q <= dvd_n;
        rem_q <= rem_n;
        if (last_step) begin
          // phase -> rounded table index: (2*phase*N + P) / (2*P)
          dvd_q <= DVW'({rem_n[39:0], {(TB + 1){1'b0}}}) + DVW'(cfg_i.period_samples);
          rem_q <= '0;
          dvs_q <= {cfg_i.period_samples, 1'b0};
        end
      end
      S_IDX: begin
        dvd_q <= dvd_n;
        rem_q <= rem_n;
        if (last_step) idx_q <= dvd_n[TB-1:0];
      end
      S_LUT: sine_q <= sine_rom[idx_q];
      S_MUL: prod_q <= prod_d;
      S_RND: delay_q <= delay_rnd;
      default: ;
    endcase
  end

  assign done_o  = done_q;
  assign delay_o = delay_q;

endmodule

>>> hdl/svdl_back.sv
module svdl_back #(
  parameter int MAX_DELAY   = 4096,
  parameter int SAMPLE_BITS = 16,
  parameter int DW          = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  svdl_pkg::in_item_t  item_i,
  output logic                item_pop_o,
  output logic                calc_start_o,
  input  logic                calc_done_i,
  input  logic [DW-1:0]       calc_delay_i,
  output logic                out_valid_o,
  output svdl_pkg::out_item_t out_data_o,
  input  logic                out_pop_i
);
  import svdl_pkg::*;

  localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int SB = SAMPLE_BITS;

  localparam logic [1:0] B_IDLE   = 2'd0;
  localparam logic [1:0] B_CALC   = 2'd1;
  localparam logic [1:0] B_FILL   = 2'd2;
  localparam logic [1:0] B_SAMPLE = 2'd3;

  function automatic logic [AW-1:0] ptr_add(logic [AW-1:0] p, logic [DW-1:0] n);
    logic [DW:0] s;
    s = (DW + 1)'(p) + (DW + 1)'(n);
    if (s >= (DW + 1)'(MAX_DELAY)) s = s - (DW + 1)'(MAX_DELAY);
    return s[AW-1:0];
  endfunction

  logic [1:0]      state_q;
  logic [AW-1:0]   head_q;
  logic [DW-1:0]   fill_q;
  logic [DW-1:0]   delay_q;
  logic [2*SB-1:0] store_q [MAX_DELAY];
  logic [2*SB-1:0] rd_q;
  logic [2*SB-1:0] pass_smp_q;
  logic            pass_q;
  logic            issued_q;

  out_item_t       ofifo_q [4];
  logic [1:0]      owr_q;
  logic [1:0]      ord_q;
  logic [2:0]      ocnt_q;

  logic            space;
  logic            issue;
  logic            bypass;
  logic [AW-1:0]   tail;
  logic            we;
  logic [2*SB-1:0] wd;
  logic [2*SB-1:0] smp;
  logic [2*SB-1:0] res;
  out_item_t       res_item;
  logic            opop;

  assign space  = ({1'b0, ocnt_q} + {3'b0, issued_q}) < 4'd4;
  assign issue  = ((state_q == B_IDLE && item_valid_i && !item_i.block_start) ||
                   state_q == B_SAMPLE) && space;
  assign bypass = (delay_q == '0) || (fill_q == '0);
  assign tail   = ptr_add(head_q, fill_q);
  assign smp    = {SB'($unsigned(item_i.sample_i)), SB'($unsigned(item_i.sample_q))};
  assign we     = (state_q == B_FILL) || (issue && !bypass);
  assign wd     = (state_q == B_FILL) ? '0 : smp;

  assign item_pop_o   = issue;
  assign calc_start_o = (state_q == B_IDLE) && item_valid_i && item_i.block_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      head_q   <= '0;
      fill_q   <= '0;
      delay_q  <= '0;
      issued_q <= 1'b0;
    end else begin
      issued_q <= issue;
      case (state_q)
        B_IDLE: begin
          if (calc_start_o) state_q <= B_CALC;
        end
        B_CALC: begin
          if (calc_done_i) begin
            delay_q <= calc_delay_i;
            if (fill_q < calc_delay_i) begin
              state_q <= B_FILL;
            end else begin
              // drop the oldest held samples
              head_q  <= ptr_add(head_q, fill_q - calc_delay_i);
              fill_q  <= calc_delay_i;
              state_q <= B_SAMPLE;
            end
          end
        end
        B_FILL: begin
          fill_q <= fill_q + DW'(1);
          if (fill_q + DW'(1) == delay_q) state_q <= B_SAMPLE;
        end
        B_SAMPLE: begin
          if (issue) state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
      if (issue && !bypass) head_q <= ptr_add(head_q, DW'(1));
    end
  end

  // read of the oldest entry sees the old word when the same entry is rewritten
  always_ff @(posedge clk_i) begin
    if (we) store_q[tail] <= wd;
    rd_q <= store_q[head_q];
    if (issue) begin
      pass_q     <= bypass;
      pass_smp_q <= smp;
    end
  end

  assign res            = pass_q ? pass_smp_q : rd_q;
  assign res_item.out_i = 16'(res[2*SB-1:SB]);
  assign res_item.out_q = 16'(res[SB-1:0]);

  assign out_valid_o = (ocnt_q != 3'd0);
  assign out_data_o  = ofifo_q[ord_q];
  assign opop        = out_pop_i && out_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (issued_q) owr_q <= owr_q + 2'd1;
      if (opop) ord_q <= ord_q + 2'd1;
      ocnt_q <= ocnt_q + {2'b0, issued_q} - {2'b0, opop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (issued_q) ofifo_q[owr_q] <= res_item;
  end

endmodule

>>> tb/sv/testbench.sv
module testbench;
  import svdl_pkg::*;

  localparam int STORE_DEPTH = 4096;
  localparam int TBL_BITS    = 10;
  localparam int TBL_N       = 1 << TBL_BITS;
  localparam logic [39:0] ALL40 = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] ALL48 = 48'hFFFF_FFFF_FFFF;

  typedef enum logic { ROW_SAMPLE, ROW_REG } row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [39:0]          reg_val;
    in_item_t             smp;
    bit                   known;
    out_item_t            want;
  } row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 push;
  logic                 full;
  in_item_t             in_data;
  logic                 empty;
  logic                 pop;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [39:0]          cfg_data;

  // predictor state
  logic signed [15:0] sine_q15 [TBL_N];
  logic [15:0]        line_i   [STORE_DEPTH];
  logic [15:0]        line_q   [STORE_DEPTH];
  int unsigned        head_ptr;
  int unsigned        held;
  int unsigned        delay_now;
  cfg_t               regs;

  out_item_t   delayed_q[$];
  int          n_mismatch;
  int          n_results;
  int          n_blocks;
  int unsigned idle_pct;
  int unsigned stall_pct;

  sinusoidal_variable_delay_line i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("FAIL sinusoidal_variable_delay_line");
    $finish;
  end

  function automatic logic signed [15:0] taylor_q15(longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned dec;
    longint unsigned s;
    x  = (r * longint'(TWO_PI_Q30) + TBL_N / 2) / TBL_N;
    x2 = (x * x) >> 30;
    t  = longint'(Q30_ONE);
    for (longint unsigned m = 12; m >= 2; m -= 2) begin
      dec = ((x2 * t) >> 30) / (m * (m + 1));
      t = (dec >= longint'(Q30_ONE)) ? 0 : longint'(Q30_ONE) - dec;
    end
    s = (((x * t) >> 30) + (1 << 14)) >> 15;
    if (s > 32767) s = 32767;
    return 16'(s);
  endfunction

  function automatic int unsigned target_samples(logic [47:0] stamp);
    longint lo;
    longint hi;
    longint d;
    longint num;
    longint part;
    longint unsigned phase;
    longint unsigned idx;
    lo = regs.delay_min_samples;
    hi = regs.delay_max_samples;
    if (regs.period_samples == 0) begin
      d = hi;
    end else begin
      phase = (longint'(stamp) + regs.start_offset_samples) % regs.period_samples;
      idx = ((phase << TBL_BITS) * 2 + regs.period_samples) / (2 * regs.period_samples);
      num = (hi - lo) * (32768 + longint'(sine_q15[idx % TBL_N]));
      part = (num >= 0) ? (num + 32768) / 65536 : -((-num + 32768) / 65536);
      d = lo + part;
    end
    if (d < 0) d = 0;
    if (d > STORE_DEPTH) d = STORE_DEPTH;
    return int'(d);
  endfunction

  function automatic out_item_t delay_sample(in_item_t it);
    out_item_t   o;
    int unsigned d;
    if (it.block_start) begin
      d = target_samples(it.block_time);
      delay_now = d;
      while (held < d) begin
        line_i[(head_ptr + held) % STORE_DEPTH] = '0;
        line_q[(head_ptr + held) % STORE_DEPTH] = '0;
        held++;
      end
      if (held > d) begin
        head_ptr = (head_ptr + held - d) % STORE_DEPTH;
        held = d;
      end
    end
    if (delay_now == 0 || held == 0) begin
      o.out_i = it.sample_i;
      o.out_q = it.sample_q;
    end else begin
      o.out_i = line_i[head_ptr];
      o.out_q = line_q[head_ptr];
      head_ptr = (head_ptr + 1) % STORE_DEPTH;
      line_i[(head_ptr + held - 1) % STORE_DEPTH] = it.sample_i;
      line_q[(head_ptr + held - 1) % STORE_DEPTH] = it.sample_q;
    end
    return o;
  endfunction

  // result side: compare each popped sample against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      n_results++;
      if (delayed_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result i=%0d q=%0d", out_data.out_i,
                                       out_data.out_q);
      end else begin
        if (out_data !== delayed_q[0]) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected i=%0d q=%0d, got i=%0d q=%0d",
                     delayed_q[0].out_i, delayed_q[0].out_q, out_data.out_i, out_data.out_q);
        end
        void'(delayed_q.pop_front());
      end
    end
    pop <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  task automatic send_sample(in_item_t it, bit known, out_item_t want);
    out_item_t p;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    p = delay_sample(it);
    if (it.block_start) n_blocks++;
    if (known && p !== want) begin
      n_mismatch++;
      if (n_mismatch <= 10) $display("predictor disagrees with table row");
    end
    delayed_q.push_back(known ? want : p);
  endtask

  task automatic drain_line();
    push <= 1'b0;
    while (delayed_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [39:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_DELAY_MIN:    regs.delay_min_samples    = val[12:0];
      CFG_DELAY_MAX:    regs.delay_max_samples    = val[12:0];
      CFG_PERIOD:       regs.period_samples       = val;
      CFG_START_OFFSET: regs.start_offset_samples = val;
      default: ;
    endcase
  endtask

  function automatic in_item_t rand_sample(int unsigned start_pct);
    in_item_t it;
    it.sample_i    = 16'($urandom);
    it.sample_q    = 16'($urandom);
    it.block_start = ($urandom_range(99) < start_pct);
    it.block_time  = ($urandom_range(3) == 0) ? 48'($urandom_range(5000)) :
                     {16'($urandom), 32'($urandom)};
    return it;
  endfunction

  function automatic row_t smp_row(logic [15:0] si, logic [15:0] sq, bit st, logic [47:0] ts,
                                   bit known, logic [15:0] wi, logic [15:0] wq);
    row_t r;
    r.kind = ROW_SAMPLE;
    r.reg_idx = CFG_DELAY_MIN;
    r.reg_val = '0;
    r.smp = '{sample_i: si, sample_q: sq, block_start: st, block_time: ts};
    r.known = known;
    r.want = '{out_i: wi, out_q: wq};
    return r;
  endfunction

  function automatic row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [39:0] val);
    row_t r;
    r = smp_row('0, '0, 1'b0, '0, 1'b0, '0, '0);
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  initial begin
    row_t        rows[$];
    in_item_t    it;
    out_item_t   none;
    int unsigned phase_mode;
    for (int k = 0; k < TBL_N; k++) begin
      int unsigned quad;
      int unsigned rem;
      logic signed [15:0] v;
      quad = k / (TBL_N / 4);
      rem  = k % (TBL_N / 4);
      v = quad[0] ? taylor_q15(TBL_N / 4 - rem) : taylor_q15(rem);
      sine_q15[k] = quad[1] ? -v : v;
    end
    for (int k = 0; k < STORE_DEPTH; k++) begin
      line_i[k] = '0;
      line_q[k] = '0;
    end
    head_ptr = 0; held = 0; delay_now = 0; regs = '0;
    n_mismatch = 0; n_results = 0; n_blocks = 0;
    idle_pct = 0; stall_pct = 0;
    none = '0;
    rst_n = 1'b0; push = 1'b0; in_data = '0; pop = 1'b0;
    cfg_valid = 1'b0; cfg_index = CFG_DELAY_MIN; cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset: zero delay passes samples straight through
    rows.push_back(smp_row(16'h7FFF, 16'h8000, 1'b0, '0, 1'b1, 16'h7FFF, 16'h8000));
    rows.push_back(smp_row(16'h8000, 16'h7FFF, 1'b1, '0, 1'b1, 16'h8000, 16'h7FFF));
    rows.push_back(smp_row(16'hFFFF, 16'h0000, 1'b1, ALL48, 1'b1, 16'hFFFF, 16'h0000));
    // constant delay of three: zeros first, then the held samples
    rows.push_back(reg_row(CFG_DELAY_MAX, 40'd3));
    rows.push_back(smp_row(16'h1111, 16'hAAAA, 1'b1, '0, 1'b1, '0, '0));
    rows.push_back(smp_row(16'h2222, 16'hBBBB, 1'b0, '0, 1'b1, '0, '0));
    rows.push_back(smp_row(16'h3333, 16'hCCCC, 1'b0, '0, 1'b1, '0, '0));
    rows.push_back(smp_row(16'h4444, 16'hDDDD, 1'b0, '0, 1'b1, 16'h1111, 16'hAAAA));
    rows.push_back(smp_row(16'h5555, 16'hEEEE, 1'b1, 48'd7, 1'b1, 16'h2222, 16'hBBBB));
    // max above store depth saturates, zeros go in behind the held samples
    rows.push_back(reg_row(CFG_DELAY_MAX, 40'h1FFF));
    rows.push_back(smp_row(16'h0001, 16'h0002, 1'b1, '0, 1'b1, 16'h3333, 16'hCCCC));
    // min above max, period of one, offset at its top
    rows.push_back(reg_row(CFG_DELAY_MIN, 40'd4096));
    rows.push_back(reg_row(CFG_DELAY_MAX, 40'd1));
    rows.push_back(reg_row(CFG_PERIOD, 40'd1));
    rows.push_back(reg_row(CFG_START_OFFSET, ALL40));
    rows.push_back(smp_row(16'h1234, 16'h5678, 1'b1, ALL48, 1'b0, '0, '0));
    rows.push_back(smp_row(16'h9ABC, 16'hDEF0, 1'b0, '0, 1'b0, '0, '0));
    // widest period, drop when delay shrinks
    rows.push_back(reg_row(CFG_DELAY_MIN, 40'd0));
    rows.push_back(reg_row(CFG_DELAY_MAX, 40'd16));
    rows.push_back(reg_row(CFG_PERIOD, ALL40));
    rows.push_back(reg_row(CFG_START_OFFSET, 40'd0));
    rows.push_back(smp_row(16'h0F0F, 16'hF0F0, 1'b1, 48'h40_0000_0000, 1'b0, '0, '0));
    rows.push_back(smp_row(16'h7F7F, 16'h8080, 1'b1, 48'hC0_0000_0000, 1'b0, '0, '0));
    rows.push_back(smp_row(16'h0000, 16'hFFFF, 1'b0, '0, 1'b0, '0, '0));

    foreach (rows[n]) begin
      if (rows[n].kind == ROW_REG) begin
        drain_line();
        write_reg(rows[n].reg_idx, rows[n].reg_val);
      end else begin
        send_sample(rows[n].smp, rows[n].known, rows[n].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      phase_mode = ph % 4;
      idle_pct  = (phase_mode == 1) ? 79 : (phase_mode == 3) ? 35 : 0;
      stall_pct = (phase_mode == 2) ? 79 : (phase_mode == 3) ? 35 : 0;
      drain_line();
      if (ph == 0) begin
        write_reg(CFG_DELAY_MIN, 40'd0);
        write_reg(CFG_DELAY_MAX, 40'd4096);
        write_reg(CFG_PERIOD, ALL40);
        write_reg(CFG_START_OFFSET, ALL40);
      end else begin
        write_reg(CFG_DELAY_MIN, 40'($urandom_range(40)));
        write_reg(CFG_DELAY_MAX, 40'($urandom_range(8) == 0 ? $urandom_range(8191) :
                                     $urandom_range(60)));
        write_reg(CFG_PERIOD, ($urandom_range(3) == 0) ? 40'd0 :
                              ($urandom_range(1) == 0) ? 40'($urandom_range(1, 5000)) :
                              {8'($urandom), 32'($urandom)});
        write_reg(CFG_START_OFFSET, {8'($urandom), 32'($urandom)});
      end
      for (int n = 0; n < 235; n++) begin
        if (ph == 5 && n == 100) drain_line();
        it = rand_sample(n == 0 ? 100 : 4);
        send_sample(it, 1'b0, none);
      end
    end

    drain_line();
    repeat (20) @(posedge clk);
    $display("covered %0d results over %0d block starts, 8 register settings", n_results,
             n_blocks);
    $display("idle and stall mixes: none, sender, receiver, both; %0d mismatches", n_mismatch);
    if (n_mismatch == 0 && delayed_q.size() == 0) begin
      $display("PASS sinusoidal_variable_delay_line");
    end else begin
      $display("FAIL sinusoidal_variable_delay_line");
    end
    $finish;
  end
endmodule
